@@ rtl/hrbe_pkg.sv @@
package hrbe_pkg;

  // default widths of the body counter and the chunk size register
  localparam int BODY_COUNT_BITS_DEF = 24;
  localparam int CHUNK_SIZE_BITS_DEF = 32;

  // register file
  localparam int MAX_BODY_BITS = 24;
  localparam logic [MAX_BODY_BITS-1:0] MAX_BODY_RESET = 24'hFFFFFF;
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam logic [0:0] REG_MAX_BODY = 1'b0;

  // field widths
  localparam int STATUS_BITS = 16;
  localparam int LENGTH_BITS = 24;
  localparam logic [STATUS_BITS-1:0] STATUS_MAX = 16'hFFFF;

  // result kinds
  localparam logic KIND_BODY    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // summary error codes
  localparam logic [1:0] ERR_OK            = 2'd0;
  localparam logic [1:0] ERR_NO_DATA       = 2'd1;
  localparam logic [1:0] ERR_NO_HEADER_END = 2'd2;

  // characters
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [23:0] CR_LF_CR  = 24'h0D0A0D;

  // header pattern, first character in the top byte
  localparam int NEEDLE_LEN = 26;
  localparam logic [NEEDLE_LEN*8-1:0] NEEDLE = "transfer-encoding: chunked";

  // result queue depth, a power of two of at least two
  localparam int RESULT_DEPTH = 4;

  typedef struct packed {
    logic                   result_kind;
    logic [7:0]             out_byte;
    logic [STATUS_BITS-1:0] status_code;
    logic [1:0]             error_code;
    logic [LENGTH_BITS-1:0] body_length;
    logic                   was_chunked;
    logic                   last_in_run;
  } result_t;

  typedef enum logic [3:0] {
    ST_WORD   = 4'b0001,
    ST_SPACE  = 4'b0010,
    ST_DIGITS = 4'b0100,
    ST_STOP   = 4'b1000
  } status_phase_t;

  typedef enum logic [4:0] {
    PH_HEX  = 5'b00001,
    PH_SKIP = 5'b00010,
    PH_DATA = 5'b00100,
    PH_TAIL = 5'b01000,
    PH_DONE = 5'b10000
  } chunk_phase_t;

endpackage

@@ rtl/hrbe_channels.sv @@
interface hrbe_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       byte_valid;
  logic       end_of_response;

  modport source (output valid, in_byte, byte_valid, end_of_response, input ready);
  modport sink (input valid, in_byte, byte_valid, end_of_response, output ready);
endinterface

interface hrbe_result_if;
  logic                             valid;
  logic                             ready;
  logic                             result_kind;
  logic [7:0]                       out_byte;
  logic [hrbe_pkg::STATUS_BITS-1:0] status_code;
  logic [1:0]                       error_code;
  logic [hrbe_pkg::LENGTH_BITS-1:0] body_length;
  logic                             was_chunked;
  logic                             last_in_run;

  modport source (output valid, result_kind, out_byte, status_code, error_code,
                  body_length, was_chunked, last_in_run, input ready);
  modport sink (input valid, result_kind, out_byte, status_code, error_code,
                body_length, was_chunked, last_in_run, output ready);
endinterface

@@ rtl/hrbe_result_fifo.sv @@
module hrbe_result_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                push_two,
  input  hrbe_pkg::result_t   first,
  input  hrbe_pkg::result_t   second,
  output logic                room,
  hrbe_result_if.source       result
);

  localparam int DEPTH    = hrbe_pkg::RESULT_DEPTH;
  localparam int PTR_BITS = $clog2(DEPTH);

  hrbe_pkg::result_t mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;
  logic [PTR_BITS:0]   push_n;
  logic                pop;
  hrbe_pkg::result_t   head;

  assign pop    = result.valid && result.ready;
  assign push_n = push ? (push_two ? (PTR_BITS+1)'(2) : (PTR_BITS+1)'(1)) : '0;
  // room for a full pair, judged on the registered count
  assign room   = count <= (PTR_BITS+1)'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= first;
      if (push_two) begin
        mem[wr_ptr + PTR_BITS'(1)] <= second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[PTR_BITS-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count + push_n - (pop ? (PTR_BITS+1)'(1) : '0);
    end
  end

  assign head               = mem[rd_ptr];
  assign result.valid       = count != '0;
  assign result.result_kind = head.result_kind;
  assign result.out_byte    = head.out_byte;
  assign result.status_code = head.status_code;
  assign result.error_code  = head.error_code;
  assign result.body_length = head.body_length;
  assign result.was_chunked = head.was_chunked;
  assign result.last_in_run = head.last_in_run;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_BITS+1)'(DEPTH))
    else $error("result queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> room)
    else $error("push without room for a pair");
`endif

endmodule

@@ rtl/http_response_body_extractor_core.sv @@
// http response body extractor
// stream channel: one raw response byte per transfer (in_byte with byte_valid),
// end_of_response closes the response; an item with neither flag gives nothing
// result channel: body bytes (result_kind 0), then one summary (result_kind 1)
// with status, error code, body length and chunked flag; last_in_run marks the
// final result caused by one stream item
// a stream item passes the input register, then the result queue, before its
// first result can be transferred
// throughput: one stream item per cycle while results drain; an item that
// ends the response after a delivered byte gives two results, and the result
// channel moves one per cycle, so sustained runs of such items follow its pace
// a 4-entry result queue parts the two sides; stream ready falls only when the
// queue cannot take a full pair, so a stalled receiver holds at most the
// queue plus the one input register
// reset (rst, synchronous) clears all stream state and the queue and sets
// max_body to its full value; after each summary the stream state returns to
// reset while max_body keeps its value
// max_body is to be written over the apb port only while the block is idle; the block does not enforce it
module http_response_body_extractor_core #(
  parameter int BODY_COUNT_BITS = hrbe_pkg::BODY_COUNT_BITS_DEF,
  parameter int CHUNK_SIZE_BITS = hrbe_pkg::CHUNK_SIZE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hrbe_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [hrbe_pkg::DATA_BITS-1:0]   pwdata,
  output logic [hrbe_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready,
  hrbe_stream_if.sink                      stream,
  hrbe_result_if.source                    result
);

  localparam int MB_BITS  = hrbe_pkg::MAX_BODY_BITS;
  localparam int CMP_BITS = (BODY_COUNT_BITS > MB_BITS) ? BODY_COUNT_BITS : MB_BITS;
  localparam int WIN_BITS = hrbe_pkg::NEEDLE_LEN * 8;

  // register file
  logic [MB_BITS-1:0] max_body;
  logic [0:0]         reg_index;
  logic               reg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[hrbe_pkg::ADDR_BITS-1:2];
  assign reg_write = psel && penable && pwrite && pready;
  assign prdata    = (reg_index == hrbe_pkg::REG_MAX_BODY)
                     ? hrbe_pkg::DATA_BITS'(max_body) : '0;

  // input register
  logic       stg_valid;
  logic [7:0] stg_byte;
  logic       stg_byte_valid;
  logic       stg_eor;
  logic       room;
  logic       proc;
  logic       take;

  assign proc         = stg_valid && room;
  assign stream.ready = !stg_valid || room;
  assign take         = stream.valid && stream.ready;

  // stream state
  hrbe_pkg::status_phase_t        status_phase, status_phase_next;
  logic [hrbe_pkg::STATUS_BITS-1:0] status_value, status_value_next;
  logic [23:0]                    recent_bytes, recent_bytes_next;
  logic [WIN_BITS-1:0]            header_window, header_window_next;
  logic                           header_done, header_done_next;
  logic                           chunked_seen, chunked_seen_next;
  hrbe_pkg::chunk_phase_t         chunk_phase, chunk_phase_next;
  logic [CHUNK_SIZE_BITS-1:0]     chunk_remaining, chunk_remaining_next;
  logic                           size_digit_seen, size_digit_seen_next;
  logic [BODY_COUNT_BITS-1:0]     delivered_count, delivered_count_next;
  logic                           any_byte_seen, any_byte_seen_next;

  // results of the current item
  logic              push;
  logic              push_two;
  hrbe_pkg::result_t first;
  hrbe_pkg::result_t second;

  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= "0" && b <= "9") begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= "a" && b <= "f") begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= "A" && b <= "F") begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  always_comb begin
    logic              is_digit;
    logic [19:0]       scaled;
    logic [7:0]        folded;
    logic [4:0]        hex;
    logic              can_deliver;
    logic              body_hit;
    logic              line_ok;
    hrbe_pkg::result_t body_res;
    hrbe_pkg::result_t summary;

    status_phase_next    = status_phase;
    status_value_next    = status_value;
    recent_bytes_next    = recent_bytes;
    header_window_next   = header_window;
    header_done_next     = header_done;
    chunked_seen_next    = chunked_seen;
    chunk_phase_next     = chunk_phase;
    chunk_remaining_next = chunk_remaining;
    size_digit_seen_next = size_digit_seen;
    delivered_count_next = delivered_count;
    any_byte_seen_next   = any_byte_seen;
    body_hit             = 1'b0;

    is_digit = stg_byte >= "0" && stg_byte <= "9";
    scaled   = 20'(status_value) * 20'd10 + 20'(stg_byte - 8'h30);
    folded   = (stg_byte >= "A" && stg_byte <= "Z") ? stg_byte + 8'h20 : stg_byte;
    hex      = hex_value(stg_byte);
    line_ok  = size_digit_seen && (chunk_remaining != '0);

    can_deliver = (CMP_BITS'(delivered_count) < CMP_BITS'(max_body))
                  && (delivered_count != '1);

    if (stg_byte_valid) begin
      any_byte_seen_next = 1'b1;

      // status code: skip the first word, then the spaces, then digits
      unique case (status_phase)
        hrbe_pkg::ST_WORD: begin
          if (stg_byte == hrbe_pkg::CHAR_NUL) begin
            status_phase_next = hrbe_pkg::ST_STOP;
          end else if (stg_byte == hrbe_pkg::CHAR_SPACE) begin
            status_phase_next = hrbe_pkg::ST_SPACE;
          end
        end
        hrbe_pkg::ST_SPACE, hrbe_pkg::ST_DIGITS: begin
          if (stg_byte == hrbe_pkg::CHAR_NUL) begin
            status_phase_next = hrbe_pkg::ST_STOP;
          end else if (status_phase == hrbe_pkg::ST_SPACE
                       && stg_byte == hrbe_pkg::CHAR_SPACE) begin
            status_phase_next = hrbe_pkg::ST_SPACE;
          end else if (is_digit) begin
            status_value_next = (scaled > 20'(hrbe_pkg::STATUS_MAX))
                                ? hrbe_pkg::STATUS_MAX : scaled[15:0];
            status_phase_next = hrbe_pkg::ST_DIGITS;
          end else begin
            status_phase_next = hrbe_pkg::ST_STOP;
          end
        end
        hrbe_pkg::ST_STOP: begin
          status_phase_next = hrbe_pkg::ST_STOP;
        end
        default: begin
          status_phase_next = hrbe_pkg::ST_STOP;
        end
      endcase

      if (!header_done) begin
        // header: case-folded window for the pattern, raw bytes for crlfcrlf
        header_window_next = {header_window[WIN_BITS-9:0], folded};
        if (header_window_next == hrbe_pkg::NEEDLE) begin
          chunked_seen_next = 1'b1;
        end
        if (stg_byte == hrbe_pkg::CHAR_LF && recent_bytes == hrbe_pkg::CR_LF_CR) begin
          header_done_next = 1'b1;
        end
        recent_bytes_next = {recent_bytes[15:0], stg_byte};
      end else if (chunked_seen) begin
        unique case (chunk_phase)
          hrbe_pkg::PH_HEX: begin
            if (hex[4]) begin
              // saturate once the top digit is occupied
              if (chunk_remaining[CHUNK_SIZE_BITS-1 -: 4] != 4'd0) begin
                chunk_remaining_next = '1;
              end else begin
                chunk_remaining_next = {chunk_remaining[CHUNK_SIZE_BITS-5:0], hex[3:0]};
              end
              size_digit_seen_next = 1'b1;
            end else if (stg_byte == hrbe_pkg::CHAR_LF) begin
              chunk_phase_next = line_ok ? hrbe_pkg::PH_DATA : hrbe_pkg::PH_DONE;
            end else begin
              chunk_phase_next = hrbe_pkg::PH_SKIP;
            end
          end
          hrbe_pkg::PH_SKIP: begin
            if (stg_byte == hrbe_pkg::CHAR_LF) begin
              chunk_phase_next = line_ok ? hrbe_pkg::PH_DATA : hrbe_pkg::PH_DONE;
            end
          end
          hrbe_pkg::PH_DATA: begin
            body_hit             = can_deliver;
            chunk_remaining_next = chunk_remaining - CHUNK_SIZE_BITS'(1);
            if (chunk_remaining == CHUNK_SIZE_BITS'(1)) begin
              chunk_phase_next = hrbe_pkg::PH_TAIL;
            end
          end
          hrbe_pkg::PH_TAIL: begin
            if (stg_byte == hrbe_pkg::CHAR_LF) begin
              chunk_phase_next     = hrbe_pkg::PH_HEX;
              chunk_remaining_next = '0;
              size_digit_seen_next = 1'b0;
            end
          end
          hrbe_pkg::PH_DONE: begin
            chunk_phase_next = hrbe_pkg::PH_DONE;
          end
          default: begin
            chunk_phase_next = hrbe_pkg::PH_DONE;
          end
        endcase
      end else begin
        body_hit = can_deliver;
      end
    end

    if (body_hit) begin
      delivered_count_next = delivered_count + BODY_COUNT_BITS'(1);
    end

    body_res             = '0;
    body_res.result_kind = hrbe_pkg::KIND_BODY;
    body_res.out_byte    = stg_byte;
    body_res.was_chunked = chunked_seen;
    body_res.last_in_run = !stg_eor;

    summary             = '0;
    summary.result_kind = hrbe_pkg::KIND_SUMMARY;
    summary.last_in_run = 1'b1;
    if (!any_byte_seen_next) begin
      summary.error_code = hrbe_pkg::ERR_NO_DATA;
    end else if (!header_done_next) begin
      summary.error_code  = hrbe_pkg::ERR_NO_HEADER_END;
      summary.status_code = status_value_next;
    end else begin
      summary.error_code  = hrbe_pkg::ERR_OK;
      summary.status_code = status_value_next;
      summary.body_length = hrbe_pkg::LENGTH_BITS'(delivered_count_next);
      summary.was_chunked = chunked_seen_next;
    end

    push     = proc && (body_hit || stg_eor);
    push_two = body_hit && stg_eor;
    first    = body_hit ? body_res : summary;
    second   = summary;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg_byte       <= stream.in_byte;
      stg_byte_valid <= stream.byte_valid;
      stg_eor        <= stream.end_of_response;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body        <= hrbe_pkg::MAX_BODY_RESET;
      stg_valid       <= 1'b0;
      status_phase    <= hrbe_pkg::ST_WORD;
      status_value    <= '0;
      recent_bytes    <= '0;
      header_window   <= '0;
      header_done     <= 1'b0;
      chunked_seen    <= 1'b0;
      chunk_phase     <= hrbe_pkg::PH_HEX;
      chunk_remaining <= '0;
      size_digit_seen <= 1'b0;
      delivered_count <= '0;
      any_byte_seen   <= 1'b0;
    end else begin
      if (reg_write && reg_index == hrbe_pkg::REG_MAX_BODY) begin
        max_body <= pwdata[MB_BITS-1:0];
      end
      if (take) begin
        stg_valid <= 1'b1;
      end else if (proc) begin
        stg_valid <= 1'b0;
      end
      if (proc) begin
        if (stg_eor) begin
          // summary sent: back to the start of a response
          status_phase    <= hrbe_pkg::ST_WORD;
          status_value    <= '0;
          recent_bytes    <= '0;
          header_window   <= '0;
          header_done     <= 1'b0;
          chunked_seen    <= 1'b0;
          chunk_phase     <= hrbe_pkg::PH_HEX;
          chunk_remaining <= '0;
          size_digit_seen <= 1'b0;
          delivered_count <= '0;
          any_byte_seen   <= 1'b0;
        end else begin
          status_phase    <= status_phase_next;
          status_value    <= status_value_next;
          recent_bytes    <= recent_bytes_next;
          header_window   <= header_window_next;
          header_done     <= header_done_next;
          chunked_seen    <= chunked_seen_next;
          chunk_phase     <= chunk_phase_next;
          chunk_remaining <= chunk_remaining_next;
          size_digit_seen <= size_digit_seen_next;
          delivered_count <= delivered_count_next;
          any_byte_seen   <= any_byte_seen_next;
        end
      end
    end
  end

  hrbe_result_fifo u_result_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_two (push_two),
    .first    (first),
    .second   (second),
    .room     (room),
    .result   (result)
  );

`ifndef ASSERT_OFF
  a_eor_clears: assert property (@(posedge clk) disable iff (rst)
    (proc && stg_eor) |=> (!header_done && !any_byte_seen && delivered_count == '0
                           && chunk_phase == hrbe_pkg::PH_HEX))
    else $error("stream state not cleared after summary");
  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    (chunk_phase == hrbe_pkg::PH_DATA) |-> (chunk_remaining != '0))
    else $error("chunk data phase with nothing remaining");
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (stg_valid && !room) |=> (stg_valid && $stable(stg_byte) && $stable(stg_eor)))
    else $error("input register lost an item while blocked");
`endif

endmodule

@@ bench/hrbe_check_pkg.sv @@
package hrbe_check_pkg;
  import hrbe_pkg::*;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [CHUNK_SIZE_BITS_DEF-1:0] SIZE_LIMIT = '1;
  localparam logic [BODY_COUNT_BITS_DEF-1:0] BODY_LIMIT = '1;

  typedef struct {
    logic [7:0] data;
    bit         has_byte;
    bit         ends;
  } stream_item_t;

  class extractor_scoreboard;
    logic [MAX_BODY_BITS-1:0]       max_body;
    status_phase_t                  status_phase;
    logic [STATUS_BITS-1:0]         status_value;
    logic [23:0]                    last_three;
    logic [NEEDLE_LEN*8-1:0]        header_tail;
    bit                             header_done;
    bit                             chunked;
    chunk_phase_t                   chunk_phase;
    logic [CHUNK_SIZE_BITS_DEF-1:0] chunk_left;
    bit                             digit_seen;
    logic [BODY_COUNT_BITS_DEF-1:0] delivered;
    bit                             any_byte;

    result_t awaited_results[$];
    int      errors;
    int      body_bytes;
    int      responses;
    int      chunked_responses;
    int      failed_responses;

    function new();
      max_body = MAX_BODY_RESET;
      clear_response();
    endfunction

    function void clear_response();
      status_phase = ST_WORD;
      status_value = '0;
      last_three   = '0;
      header_tail  = '0;
      header_done  = 1'b0;
      chunked      = 1'b0;
      chunk_phase  = PH_HEX;
      chunk_left   = '0;
      digit_seen   = 1'b0;
      delivered    = '0;
      any_byte     = 1'b0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function bit take_body();
      if (delivered < max_body && delivered < BODY_LIMIT) begin
        delivered++;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // a size line with no digit or a zero size ends decoding
    function chunk_phase_t size_line_end();
      return (!digit_seen || chunk_left == 0) ? PH_DONE : PH_DATA;
    endfunction

    function void push_result(logic kind, logic [7:0] data, logic [STATUS_BITS-1:0] status,
                              logic [1:0] err, logic [LENGTH_BITS-1:0] len, logic ch);
      result_t r;
      r.result_kind = kind;
      r.out_byte    = data;
      r.status_code = status;
      r.error_code  = err;
      r.body_length = len;
      r.was_chunked = ch;
      r.last_in_run = 1'b0;
      awaited_results.push_back(r);
    endfunction

    function void extract_from_item(logic [7:0] b, bit has_byte, bit ends);
      logic [7:0]  folded;
      logic [3:0]  digit;
      int unsigned code;
      bit          hex;
      int          queued_earlier;
      queued_earlier = awaited_results.size();
      if (has_byte) begin
        any_byte = 1'b1;
        // status: first word, then the space run, then decimal digits
        if (status_phase != ST_STOP) begin
          if (b == CHAR_NUL) begin
            status_phase = ST_STOP;
          end else if (status_phase == ST_WORD) begin
            if (b == CHAR_SPACE) status_phase = ST_SPACE;
          end else if (!(status_phase == ST_SPACE && b == CHAR_SPACE)) begin
            if (b >= "0" && b <= "9") begin
              code = 32'(status_value) * 32'd10 + 32'(b - "0");
              status_value = (code > STATUS_MAX) ? STATUS_MAX : code[STATUS_BITS-1:0];
              status_phase = ST_DIGITS;
            end else begin
              status_phase = ST_STOP;
            end
          end
        end
        if (!header_done) begin
          folded = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
          header_tail = {header_tail[NEEDLE_LEN*8-9:0], folded};
          if (header_tail == NEEDLE) chunked = 1'b1;
          if (b == CHAR_LF && last_three == CR_LF_CR) header_done = 1'b1;
          last_three = {last_three[15:0], b};
        end else if (chunked) begin
          case (chunk_phase)
            PH_HEX: begin
              hex = 1'b1;
              digit = '0;
              if (b >= "0" && b <= "9") digit = 4'(b - "0");
              else if (b >= "a" && b <= "f") digit = 4'(b - "a" + 8'd10);
              else if (b >= "A" && b <= "F") digit = 4'(b - "A" + 8'd10);
              else hex = 1'b0;
              if (hex) begin
                chunk_left = (chunk_left > (SIZE_LIMIT >> 4)) ? SIZE_LIMIT
                                                              : (chunk_left << 4) + digit;
                digit_seen = 1'b1;
              end else if (b == CHAR_LF) begin
                chunk_phase = size_line_end();
              end else begin
                chunk_phase = PH_SKIP;
              end
            end
            PH_SKIP: if (b == CHAR_LF) chunk_phase = size_line_end();
            PH_DATA: begin
              if (take_body()) push_result(KIND_BODY, b, '0, ERR_OK, '0, 1'b1);
              chunk_left--;
              if (chunk_left == 0) chunk_phase = PH_TAIL;
            end
            PH_TAIL: if (b == CHAR_LF) begin
              chunk_phase = PH_HEX;
              chunk_left  = '0;
              digit_seen  = 1'b0;
            end
            default: ;
          endcase
        end else if (take_body()) begin
          push_result(KIND_BODY, b, '0, ERR_OK, '0, 1'b0);
        end
      end
      if (ends) begin
        if (!any_byte)
          push_result(KIND_SUMMARY, '0, '0, ERR_NO_DATA, '0, 1'b0);
        else if (!header_done)
          push_result(KIND_SUMMARY, '0, status_value, ERR_NO_HEADER_END, '0, 1'b0);
        else
          push_result(KIND_SUMMARY, '0, status_value, ERR_OK, delivered, chunked);
        clear_response();
      end
      if (awaited_results.size() > queued_earlier)
        awaited_results[awaited_results.size()-1].last_in_run = 1'b1;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        $error("result with nothing awaited: kind %0b byte %02h", got.result_kind, got.out_byte);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("result_kind", want.result_kind, got.result_kind);
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("status_code", want.status_code, got.status_code);
      compare_field("error_code", want.error_code, got.error_code);
      compare_field("body_length", want.body_length, got.body_length);
      compare_field("was_chunked", want.was_chunked, got.was_chunked);
      compare_field("last_in_run", want.last_in_run, got.last_in_run);
      if (want.result_kind == KIND_BODY) begin
        body_bytes++;
      end else begin
        responses++;
        if (want.was_chunked) chunked_responses++;
        if (want.error_code != ERR_OK) failed_responses++;
      end
    endfunction
  endclass

endpackage

@@ bench/http_response_body_extractor_core_test.sv @@
module http_response_body_extractor_core_test;
  import hrbe_pkg::*;
  import hrbe_check_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 6;
  // settle time after draining, to cover the input register and the 4-entry queue
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASE_ITEMS   = 55;
  localparam int HOLD_CYCLES   = 150;
  // backstop in simulation time units
  localparam int RUN_LIMIT     = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // apb side
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  hrbe_stream_if stream ();
  hrbe_result_if result ();

  http_response_body_extractor_core dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .stream  (stream),
    .result  (result)
  );

  extractor_scoreboard sb = new();

  stream_item_t queued_items[$];  // response bytes built but not yet sent
  int burst_left;                 // transfers left in the current sender burst
  int items_sent;                 // items that carry a byte or an end
  int results_taken;              // result transfers seen by the receiver

  always #HALF_PERIOD clk = ~clk;

  // backstop against a hung handshake
  initial begin : watchdog
    #RUN_LIMIT;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // response building
  // ---------------------------------------------------------------------------

  function automatic void add_byte(input logic [7:0] b);
    queued_items.push_back(stream_item_t'{data: b, has_byte: 1'b1, ends: 1'b0});
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_crlf();
    add_byte(CHAR_CR);
    add_byte(CHAR_LF);
  endfunction

  // end rides on the last byte, or comes as an end-only item
  function automatic void close_response(input bit end_only);
    if (!end_only && queued_items.size() != 0 && queued_items[queued_items.size()-1].has_byte)
      queued_items[queued_items.size()-1].ends = 1'b1;
    else
      queued_items.push_back(stream_item_t'{data: 8'($urandom), has_byte: 1'b0, ends: 1'b1});
  endfunction

  // mostly well-formed responses with random content; some noise,
  // some headers that never close, some broken or saturated chunk framing
  function automatic void build_response();
    string      word;
    string      size_text;
    logic [7:0] ch;
    int         size;
    bit         framed;
    if ($urandom_range(0, 9) == 0) begin
      // line noise, no structure at all
      repeat ($urandom_range(1, 20)) add_byte(8'($urandom));
      close_response($urandom_range(0, 1));
      return;
    end
    // status line: a word, a space run, the code, then text
    add_text($urandom_range(0, 3) == 0 ? "HTTP/1.1" : "H");
    repeat ($urandom_range(1, 3)) add_byte(CHAR_SPACE);
    add_text($sformatf("%0d", $urandom_range(0, 7) == 0 ? $urandom_range(0, 999999)
                                                        : $urandom_range(100, 599)));
    if ($urandom_range(0, 9) == 0) add_byte(CHAR_NUL);
    add_text(" OK");
    add_crlf();
    if ($urandom_range(0, 3) == 0) begin
      add_text("Server: x");
      add_crlf();
    end
    framed = ($urandom_range(0, 2) != 0);
    if (framed) begin
      // letter case mixed at random; now and then a near miss that must not match
      word = ($urandom_range(0, 7) == 0) ? "transfer-encoding: chunkex"
                                         : "transfer-encoding: chunked";
      for (int i = 0; i < word.len(); i++) begin
        ch = word[i];
        if (ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1) ch = ch - 8'd32;
        add_byte(ch);
      end
      add_crlf();
    end
    if ($urandom_range(0, 11) == 0) begin
      // header never closed
      repeat ($urandom_range(0, 6)) add_byte(8'($urandom));
      close_response($urandom_range(0, 1));
      return;
    end
    add_crlf();
    if (!framed) begin
      repeat ($urandom_range(0, 12)) add_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 2)) begin
        size = $urandom_range(1, 20);
        size_text = $sformatf("%0h", size);
        if ($urandom_range(0, 1) == 1) size_text = size_text.toupper();
        if ($urandom_range(0, 3) == 0) size_text = {"0", size_text};
        add_text(size_text);
        // chunk extension drops the size line into its skip state
        if ($urandom_range(0, 3) == 0) add_text(";q=1");
        add_crlf();
        repeat (size) add_byte(8'($urandom));
        // junk before the line end of the chunk tail
        if ($urandom_range(0, 3) == 0) add_text("zz");
        add_crlf();
      end
      case ($urandom_range(0, 5))
        0: begin
          // size line without a digit ends decoding, the rest is ignored
          add_crlf();
          add_text("late");
        end
        1: begin
          // size saturates, data runs until the response ends
          add_text("fffffffff");
          add_crlf();
          repeat ($urandom_range(0, 8)) add_byte(8'($urandom));
        end
        2: ;  // cut right after a chunk
        default: begin
          add_text("0");
          add_crlf();
          add_crlf();
          if ($urandom_range(0, 1) == 1) add_text("trailer");
        end
      endcase
    end
    close_response($urandom_range(0, 1));
  endfunction

  // ---------------------------------------------------------------------------
  // stream driving
  // ---------------------------------------------------------------------------

  // one transfer; the sender may idle between bursts of random length
  task automatic send_item(input stream_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        stream.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // an occasional long burst gives stretches with no idling
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    stream.valid           <= 1'b1;
    stream.in_byte         <= it.data;
    stream.byte_valid      <= it.has_byte;
    stream.end_of_response <= it.ends;
    do @(posedge clk); while (stream.ready !== 1'b1);
    sb.extract_from_item(it.data, it.has_byte, it.ends);
  endtask

  // send what was built, with an ignored empty item slipped in now and then
  task automatic send_queued();
    foreach (queued_items[i]) begin
      if ($urandom_range(0, 49) == 0)
        send_item(stream_item_t'{data: 8'($urandom), has_byte: 1'b0, ends: 1'b0});
      send_item(queued_items[i]);
      if (queued_items[i].has_byte || queued_items[i].ends) items_sent++;
    end
    queued_items.delete();
  endtask

  // sender idles until every awaited result has come, then lets the pipe settle
  task automatic wait_drained();
    int waited;
    stream.valid <= 1'b0;
    burst_left = 0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle, then access until pready
  task automatic write_max_body(input logic [MAX_BODY_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAX_BODY, 2'b00};
    pwdata  <= DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.max_body = value;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: checks each result transfer, stalls on a pattern of its own
  // ---------------------------------------------------------------------------

  initial begin : receiver
    result_t got;
    int      cycle;
    int      mode;
    int      hold_left;
    bit      hold_done;
    cycle = 0;
    mode = 0;
    hold_left = 0;
    hold_done = 1'b0;
    results_taken = 0;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result.valid === 1'b1 && result.ready === 1'b1) begin
        got = result_t'{result_kind: result.result_kind, out_byte: result.out_byte,
                        status_code: result.status_code, error_code: result.error_code,
                        body_length: result.body_length, was_chunked: result.was_chunked,
                        last_in_run: result.last_in_run};
        sb.check_result(got);
        results_taken++;
      end
      cycle++;
      if (cycle % 64 == 0) mode = $urandom_range(0, 3);
      // one long hold-off while the sender is busy, so the block backs up
      if (!hold_done && results_taken >= 40 && stream.valid === 1'b1) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        case (mode)
          0: result.ready <= 1'b1;
          1: result.ready <= 1'($urandom_range(0, 1));
          2: result.ready <= (cycle % 4 == 0);
          default: result.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : main
    logic [MAX_BODY_BITS-1:0] settings [5];
    int                       phase_end;
    stream.valid           = 1'b0;
    stream.in_byte         = '0;
    stream.byte_valid      = 1'b0;
    stream.end_of_response = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    burst_left = 0;
    items_sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part, max_body still at its reset value
    // an empty item gives nothing, then an end with no byte at all
    queued_items.push_back(stream_item_t'{data: 8'h5A, has_byte: 1'b0, ends: 1'b0});
    close_response(1'b1);
    // status saturates, header never ends
    add_text("H ");
    repeat (5) add_byte("9");
    close_response(1'b1);
    // all-ones byte as the first word, NUL stops the status digits
    add_byte(8'hFF);
    add_byte(CHAR_SPACE);
    add_byte("4");
    add_byte(CHAR_NUL);
    add_byte("2");
    close_response(1'b0);
    // bare header end, then one body byte that also ends the response: two results
    add_crlf();
    add_crlf();
    add_byte("Z");
    close_response(1'b0);
    send_queued();
    wait_drained();

    // random part over several max_body settings, extremes among them
    settings[0] = MAX_BODY_BITS'($urandom_range(1, 6));
    settings[1] = '0;
    settings[2] = MAX_BODY_RESET;
    settings[3] = MAX_BODY_BITS'($urandom_range(0, 30));
    settings[4] = MAX_BODY_BITS'($urandom_range(1, 3));
    foreach (settings[p]) begin
      write_max_body(settings[p]);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        build_response();
        send_queued();
        // now and then the sender waits for every result before going on
        if ($urandom_range(0, 5) == 0) wait_drained();
      end
      wait_drained();
    end

    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    $display("covered %0d stream items under %0d max_body settings plus the reset value",
             items_sent, $size(settings));
    $display("checked %0d responses (%0d chunked, %0d with error) and %0d body bytes",
             sb.responses, sb.chunked_responses, sb.failed_responses, sb.body_bytes);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
